// ===== src/cursor_array_list_defines.svh =====
// ----------------------------------------------------------------------------
// cursor_array_list_defines.svh
// Assertion macros used by the cursor array list module
// ----------------------------------------------------------------------------
`ifndef CURSOR_ARRAY_LIST_DEFINES_SVH
`define CURSOR_ARRAY_LIST_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define CAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define CAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cal_pkg.sv =====
// ----------------------------------------------------------------------------
// cal_pkg
// Field widths, command codes and status codes of the cursor array list
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cal_pkg;

  // default sizing
  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;

  // channel field widths
  localparam int KIND_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 4'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 4'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 4'd2;
  localparam logic [KIND_W-1:0] KIND_START  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_END    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_PREV   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_NEXT   = 4'd6;
  localparam logic [KIND_W-1:0] KIND_GOTO   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_READ   = 4'd8;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 4'd9;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 4'd10;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

endpackage

`default_nettype wire

// ===== src/cal_cmd_if.sv =====
// ----------------------------------------------------------------------------
// cal_cmd_if
// Command channel: valid/ready handshake carrying one list command
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cal_cmd_if;

  logic                        valid;
  logic                        ready;
  logic [cal_pkg::KIND_W-1:0]  kind;
  logic [cal_pkg::VALUE_W-1:0] value;
  logic [cal_pkg::POS_W-1:0]   position;

  modport source (output valid, output kind, output value, output position, input ready);
  modport sink   (input valid, input kind, input value, input position, output ready);

endinterface

`default_nettype wire

// ===== src/cal_res_if.sv =====
// ----------------------------------------------------------------------------
// cal_res_if
// Result channel: valid/ready handshake carrying one command result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cal_res_if;

  logic                         valid;
  logic                         ready;
  logic [cal_pkg::DATA_W-1:0]   data;
  logic                         found;
  logic [cal_pkg::INDEX_W-1:0]  found_index;
  logic [cal_pkg::INDEX_W-1:0]  cursor;
  logic [cal_pkg::COUNT_W-1:0]  count;
  logic [cal_pkg::STATUS_W-1:0] status;

  modport source (output valid, output data, output found, output found_index,
                  output cursor, output count, output status, input ready);
  modport sink   (input valid, input data, input found, input found_index,
                  input cursor, input count, input status, output ready);

endinterface

`default_nettype wire

// ===== src/cursor_array_list.sv =====
// ----------------------------------------------------------------------------
// cursor_array_list
// Bounded ordered list with a cursor, held in a single-port-write memory and
// walked one entry per cycle by a small sequencer
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  cmd     | in  | valid/ready | kind, value, position
//  res     | out | valid/ready | data, found, found_index, cursor, count, status
//
//  insert below the end shifts entries up from the top down to the cursor, remove
//  pulls later entries down, search scans from the head and read waits on the
//  registered memory read; shifts and scans go one entry a cycle; commands run
//  one at a time; cmd is ready only when idle with the result slot free
//  reset clears state, count, cursor and result valid; the memory needs no clearing pass
//  a stalled result holds the block idle until res takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cursor_array_list_defines.svh"

module cursor_array_list #(
  parameter int CAPACITY   = cal_pkg::CAPACITY,
  parameter int DATA_WIDTH = cal_pkg::DATA_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  cal_cmd_if.sink  cmd,
  cal_res_if.source res
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > cal_pkg::POS_W) ? CNT_W : cal_pkg::POS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SHIFT,
    ST_INS_LAST,
    ST_REM_READ,
    ST_REM_SHIFT,
    ST_READ_WAIT,
    ST_SEARCH
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            elem_count;
  logic [AW-1:0]               cur_pos;
  logic [CNT_W-1:0]            idx;
  logic [DATA_WIDTH-1:0]       op_value;
  logic                        res_valid;
  logic [DATA_WIDTH-1:0]       res_data;
  logic                        res_found;
  logic [cal_pkg::STATUS_W-1:0] res_status;

  // element memory
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [AW-1:0]         rd_addr;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [DATA_WIDTH-1:0] mem_wd;

  logic                  cmd_fire;
  logic                  list_full;
  logic                  list_empty;
  logic [DATA_WIDTH-1:0] in_value;
  logic [CNT_W-1:0]      cur_ext;
  logic [CNT_W-1:0]      count_dec;
  logic                  rem_last;
  logic [AW-1:0]         rem_cursor;
  logic                  goto_ok;

  // handshake
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cmd.ready = (state == ST_IDLE) && (!res_valid || res.ready);

  // result payload; cursor and count only move when a result is produced
  assign res.valid       = res_valid;
  assign res.data        = cal_pkg::DATA_W'(res_data);
  assign res.found       = res_found;
  assign res.found_index = res_found ? cal_pkg::INDEX_W'(idx) : '0;
  assign res.cursor      = cal_pkg::INDEX_W'(cur_pos);
  assign res.count       = cal_pkg::COUNT_W'(elem_count);
  assign res.status      = res_status;

  // shared compare and step logic
  assign in_value   = DATA_WIDTH'(cmd.value);
  assign list_full  = (elem_count == CNT_W'(CAPACITY));
  assign list_empty = (elem_count == '0);
  assign cur_ext    = CNT_W'(cur_pos);
  assign count_dec  = elem_count - 1'b1;
  assign goto_ok    = (CMP_W'(cmd.position) < CMP_W'(elem_count)) || (cmd.position == '0);

  // last step of a remove and where the cursor lands afterwards
  always_comb begin
    rem_last = 1'b0;
    if (state == ST_REM_READ) begin
      rem_last = (cur_ext + 1'b1) >= elem_count;
    end else if (state == ST_REM_SHIFT) begin
      rem_last = (idx + CNT_W'(2)) >= elem_count;
    end
    if (cur_ext >= count_dec) begin
      rem_cursor = (count_dec == '0) ? '0 : AW'(count_dec - 1'b1);
    end else begin
      rem_cursor = cur_pos;
    end
  end

  // memory address and write control
  always_comb begin
    rd_addr = '0;
    mem_we  = 1'b0;
    mem_wa  = idx[AW-1:0];
    mem_wd  = rd_data;
    unique case (state)
      ST_IDLE: begin
        if (cmd.kind == cal_pkg::KIND_INSERT) begin
          rd_addr = AW'(count_dec);
        end else if (cmd.kind == cal_pkg::KIND_REMOVE || cmd.kind == cal_pkg::KIND_READ) begin
          rd_addr = cur_pos;
        end
        if (cmd_fire && !list_full) begin
          if (cmd.kind == cal_pkg::KIND_APPEND) begin
            mem_we = 1'b1;
            mem_wa = AW'(elem_count);
            mem_wd = in_value;
          end else if (cmd.kind == cal_pkg::KIND_INSERT && cur_ext == elem_count) begin
            mem_we = 1'b1;
            mem_wa = cur_pos;
            mem_wd = in_value;
          end
        end
      end
      ST_INS_SHIFT: begin
        mem_we  = 1'b1;
        rd_addr = AW'(idx - CNT_W'(2));
      end
      ST_INS_LAST: begin
        mem_we = 1'b1;
        mem_wa = cur_pos;
        mem_wd = op_value;
      end
      ST_REM_READ: begin
        rd_addr = cur_pos + 1'b1;
      end
      ST_REM_SHIFT: begin
        mem_we  = 1'b1;
        rd_addr = AW'(idx + CNT_W'(2));
      end
      ST_READ_WAIT: begin
        rd_addr = '0;
      end
      ST_SEARCH: begin
        rd_addr = AW'(idx + 1'b1);
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // element memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer, list state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      elem_count <= '0;
      cur_pos    <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            op_value   <= in_value;
            res_data   <= '0;
            res_found  <= 1'b0;
            res_status <= cal_pkg::STAT_OK;
            unique case (cmd.kind)
              cal_pkg::KIND_INSERT: begin
                if (list_full) begin
                  res_status <= cal_pkg::STAT_FULL;
                  res_valid  <= 1'b1;
                end else if (cur_ext == elem_count) begin
                  elem_count <= elem_count + 1'b1;
                  res_valid  <= 1'b1;
                end else begin
                  idx   <= elem_count;
                  state <= ST_INS_SHIFT;
                end
              end
              cal_pkg::KIND_APPEND: begin
                if (list_full) begin
                  res_status <= cal_pkg::STAT_FULL;
                end else begin
                  elem_count <= elem_count + 1'b1;
                end
                res_valid <= 1'b1;
              end
              cal_pkg::KIND_REMOVE: begin
                if (list_empty) begin
                  res_status <= cal_pkg::STAT_EMPTY;
                  res_valid  <= 1'b1;
                end else begin
                  state <= ST_REM_READ;
                end
              end
              cal_pkg::KIND_START: begin
                cur_pos   <= '0;
                res_valid <= 1'b1;
              end
              cal_pkg::KIND_END: begin
                cur_pos   <= list_empty ? '0 : AW'(count_dec);
                res_valid <= 1'b1;
              end
              cal_pkg::KIND_PREV: begin
                if (cur_pos != '0) begin
                  cur_pos <= cur_pos - 1'b1;
                end
                res_valid <= 1'b1;
              end
              cal_pkg::KIND_NEXT: begin
                if ((cur_ext + 1'b1) < elem_count) begin
                  cur_pos <= cur_pos + 1'b1;
                end
                res_valid <= 1'b1;
              end
              cal_pkg::KIND_GOTO: begin
                if (goto_ok) begin
                  cur_pos <= AW'(cmd.position);
                end else begin
                  res_status <= cal_pkg::STAT_RANGE;
                end
                res_valid <= 1'b1;
              end
              cal_pkg::KIND_READ: begin
                if (list_empty) begin
                  res_status <= cal_pkg::STAT_EMPTY;
                  res_valid  <= 1'b1;
                end else begin
                  state <= ST_READ_WAIT;
                end
              end
              cal_pkg::KIND_SEARCH: begin
                if (list_empty) begin
                  res_valid <= 1'b1;
                end else begin
                  idx   <= '0;
                  state <= ST_SEARCH;
                end
              end
              cal_pkg::KIND_CLEAR: begin
                elem_count <= '0;
                cur_pos    <= '0;
                res_valid  <= 1'b1;
              end
              default: begin
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        // move entries up, top first, until the cursor slot is free
        ST_INS_SHIFT: begin
          if (idx == cur_ext + 1'b1) begin
            state <= ST_INS_LAST;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        ST_INS_LAST: begin
          elem_count <= elem_count + 1'b1;
          res_valid  <= 1'b1;
          state      <= ST_IDLE;
        end
        // capture the removed entry, then pull later entries down
        ST_REM_READ: begin
          res_data <= rd_data;
          idx      <= cur_ext;
          if (rem_last) begin
            elem_count <= count_dec;
            cur_pos    <= rem_cursor;
            res_valid  <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            state <= ST_REM_SHIFT;
          end
        end
        ST_REM_SHIFT: begin
          if (rem_last) begin
            elem_count <= count_dec;
            cur_pos    <= rem_cursor;
            res_valid  <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_READ_WAIT: begin
          res_data  <= rd_data;
          res_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        // linear scan from the head, first match wins
        ST_SEARCH: begin
          if (rd_data == op_value) begin
            res_found <= 1'b1;
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end else if ((idx + 1'b1) >= elem_count) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `CAL_ASSERT_NOW(a_cursor_in_list, 1'b1, (elem_count == '0) ? (cur_pos == '0) : (cur_ext < elem_count), "cursor outside the list")
  `CAL_ASSERT_NOW(a_count_bounded, 1'b1, elem_count <= CNT_W'(CAPACITY), "count above capacity")
  `CAL_ASSERT_NOW(a_no_result_while_busy, state != ST_IDLE, !res_valid, "result pending during a walk")
  `CAL_ASSERT_NEXT(a_insert_grows, state == ST_INS_LAST, elem_count == $past(elem_count) + 1'b1, "insert did not grow the list")

endmodule

`default_nettype wire

// ===== tb/sv/cal_list_checker.sv =====
// ----------------------------------------------------------------------------
// cal_list_checker
// Watches the command and result channels of the cursor array list, keeps a
// shadow copy of the list and cursor, and compares every result field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cal_list_checker (
  input  logic clk,
  input  logic rst,
  cal_cmd_if   cmd,
  cal_res_if   res,
  output int   fail_count,
  output int   outstanding,
  output int   replies_checked,
  output int   list_size,
  output int   peak_size
);

  typedef struct packed {
    logic [cal_pkg::DATA_W-1:0]   data;
    logic                         found;
    logic [cal_pkg::INDEX_W-1:0]  found_index;
    logic [cal_pkg::INDEX_W-1:0]  cursor;
    logic [cal_pkg::COUNT_W-1:0]  count;
    logic [cal_pkg::STATUS_W-1:0] status;
  } list_reply_t;

  // shadow list state
  logic [cal_pkg::DATA_W-1:0] shadow_store [cal_pkg::CAPACITY];
  int                         shadow_count  = 0;
  int                         shadow_cursor = 0;

  list_reply_t awaited_replies[$];
  int          fails   = 0;
  int          checked = 0;
  int          peak    = 0;

  // apply one command to the shadow list and return the reply it should give
  function automatic list_reply_t apply_list_command(
      input logic [cal_pkg::KIND_W-1:0]  kind,
      input logic [cal_pkg::VALUE_W-1:0] value,
      input logic [cal_pkg::POS_W-1:0]   position);
    list_reply_t reply;
    int          i;
    reply = '0;
    reply.status = cal_pkg::STAT_OK;
    case (kind)
      cal_pkg::KIND_INSERT: begin
        if (shadow_count >= cal_pkg::CAPACITY) begin
          reply.status = cal_pkg::STAT_FULL;
        end else begin
          for (i = shadow_count; i > shadow_cursor; i--)
            shadow_store[i] = shadow_store[i-1];
          shadow_store[shadow_cursor] = value;
          shadow_count++;
        end
      end
      cal_pkg::KIND_APPEND: begin
        if (shadow_count >= cal_pkg::CAPACITY) begin
          reply.status = cal_pkg::STAT_FULL;
        end else begin
          shadow_store[shadow_count] = value;
          shadow_count++;
        end
      end
      cal_pkg::KIND_REMOVE: begin
        if (shadow_count == 0) begin
          reply.status = cal_pkg::STAT_EMPTY;
        end else begin
          reply.data = shadow_store[shadow_cursor];
          for (i = shadow_cursor; i + 1 < shadow_count; i++)
            shadow_store[i] = shadow_store[i+1];
          shadow_count--;
          // cursor falls back onto the last entry
          if (shadow_cursor >= shadow_count)
            shadow_cursor = (shadow_count > 0) ? shadow_count - 1 : 0;
        end
      end
      cal_pkg::KIND_START: shadow_cursor = 0;
      cal_pkg::KIND_END:   shadow_cursor = (shadow_count > 0) ? shadow_count - 1 : 0;
      cal_pkg::KIND_PREV: begin
        if (shadow_cursor > 0)
          shadow_cursor--;
      end
      cal_pkg::KIND_NEXT: begin
        if (shadow_cursor + 1 < shadow_count)
          shadow_cursor++;
      end
      cal_pkg::KIND_GOTO: begin
        if (int'(position) < shadow_count || position == 0)
          shadow_cursor = int'(position);
        else
          reply.status = cal_pkg::STAT_RANGE;
      end
      cal_pkg::KIND_READ: begin
        if (shadow_count == 0)
          reply.status = cal_pkg::STAT_EMPTY;
        else
          reply.data = shadow_store[shadow_cursor];
      end
      cal_pkg::KIND_SEARCH: begin
        // first equal entry wins
        for (i = 0; i < shadow_count; i++) begin
          if (!reply.found && shadow_store[i] == value) begin
            reply.found       = 1'b1;
            reply.found_index = i[cal_pkg::INDEX_W-1:0];
          end
        end
      end
      cal_pkg::KIND_CLEAR: begin
        shadow_count  = 0;
        shadow_cursor = 0;
      end
      default: ;
    endcase
    reply.cursor = shadow_cursor[cal_pkg::INDEX_W-1:0];
    reply.count  = shadow_count[cal_pkg::COUNT_W-1:0];
    return reply;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  // sample both channels at each edge
  always @(posedge clk) begin
    list_reply_t want;
    if (rst) begin
      shadow_count  = 0;
      shadow_cursor = 0;
      awaited_replies.delete();
    end else begin
      // compare the result first so a same-edge request cannot cover for it
      if (res.valid && res.ready) begin
        checked++;
        if (awaited_replies.size() == 0) begin
          $error("result with no request waiting: cursor %0d count %0d status %0d",
                 res.cursor, res.count, res.status);
          fails++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("data", 32'(want.data), 32'(res.data));
          check_field("found", 32'(want.found), 32'(res.found));
          check_field("found_index", 32'(want.found_index), 32'(res.found_index));
          check_field("cursor", 32'(want.cursor), 32'(res.cursor));
          check_field("count", 32'(want.count), 32'(res.count));
          check_field("status", 32'(want.status), 32'(res.status));
        end
      end
      if (cmd.valid && cmd.ready) begin
        awaited_replies.push_back(apply_list_command(cmd.kind, cmd.value, cmd.position));
        if (shadow_count > peak)
          peak = shadow_count;
      end
    end
    fail_count      <= fails;
    outstanding     <= awaited_replies.size();
    replies_checked <= checked;
    list_size       <= shadow_count;
    peak_size       <= peak;
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the cursor array list with directed and random list commands under
// random gaps and result stalls; a checker instance predicts every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // command codes the block leaves unused
  localparam logic [cal_pkg::KIND_W-1:0] KIND_SPARE_LO = 4'd11;
  localparam logic [cal_pkg::KIND_W-1:0] KIND_SPARE_HI = 4'd15;

  localparam logic [cal_pkg::VALUE_W-1:0] TAIL_MARK = 32'h9E37_79B9;
  localparam int RANDOM_ITEMS = 60;
  localparam int DRAIN_CYCLES = 300;

  logic clk;
  logic rst;
  bit   steady = 1'b0;
  int   sent   = 0;

  int fail_count;
  int outstanding;
  int replies_checked;
  int list_size;
  int peak_size;

  cal_cmd_if cmd ();
  cal_res_if res ();

  cursor_array_list dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  cal_list_checker list_check (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .res             (res),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .replies_checked (replies_checked),
    .list_size       (list_size),
    .peak_size       (peak_size)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard limit on run time
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // values mostly from a small pool so searches hit, with extremes and noise
  function automatic logic [cal_pkg::VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)
      return cal_pkg::VALUE_W'($urandom_range(0, 15));
    if (r < 55)
      return '0;
    if (r < 60)
      return '1;
    return $urandom;
  endfunction

  // goto targets: mostly in range, some at the edge, some anywhere
  function automatic logic [cal_pkg::POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60 && list_size > 0)
      return cal_pkg::POS_W'($urandom_range(0, list_size));
    if (r < 75)
      return '0;
    return cal_pkg::POS_W'($urandom_range(0, 255));
  endfunction

  // present one request and hold it until accepted, then maybe pause
  task automatic send_cmd(input logic [cal_pkg::KIND_W-1:0]  kind,
                          input logic [cal_pkg::VALUE_W-1:0] value,
                          input logic [cal_pkg::POS_W-1:0]   position);
    int gap;
    cmd.valid    <= 1'b1;
    cmd.kind     <= kind;
    cmd.value    <= value;
    cmd.position <= position;
    @(posedge clk);
    while (!cmd.ready)
      @(posedge clk);
    sent++;
    gap = idle_len();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: runs of ready broken by stalls
  initial begin
    int run;
    int gap;
    res.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = idle_len();
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res.ready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int r;
    rst          <= 1'b1;
    cmd.valid    <= 1'b0;
    cmd.kind     <= cal_pkg::KIND_READ;
    cmd.value    <= '0;
    cmd.position <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty list, boundaries and range errors
    send_cmd(cal_pkg::KIND_READ, '0, '0);
    send_cmd(cal_pkg::KIND_REMOVE, '0, '0);
    send_cmd(cal_pkg::KIND_SEARCH, '0, '0);
    send_cmd(cal_pkg::KIND_END, '0, '0);
    send_cmd(cal_pkg::KIND_PREV, '0, '0);
    send_cmd(cal_pkg::KIND_NEXT, '0, '0);
    send_cmd(cal_pkg::KIND_GOTO, '0, 8'd0);
    send_cmd(cal_pkg::KIND_GOTO, '0, 8'd1);
    send_cmd(cal_pkg::KIND_APPEND, 32'hFFFF_FFFF, '0);
    send_cmd(cal_pkg::KIND_APPEND, 32'h0000_0000, '0);
    send_cmd(cal_pkg::KIND_INSERT, 32'hA5A5_5A5A, '0);
    send_cmd(cal_pkg::KIND_GOTO, '0, 8'd255);
    send_cmd(cal_pkg::KIND_GOTO, '0, 8'd2);
    send_cmd(cal_pkg::KIND_NEXT, '0, '0);
    send_cmd(cal_pkg::KIND_READ, '0, '0);
    send_cmd(cal_pkg::KIND_PREV, '0, '0);
    send_cmd(cal_pkg::KIND_SEARCH, 32'h0000_0000, '0);
    send_cmd(cal_pkg::KIND_SEARCH, 32'h1234_5678, '0);
    send_cmd(cal_pkg::KIND_END, '0, '0);
    // removing the last entry pulls the cursor back
    send_cmd(cal_pkg::KIND_REMOVE, '0, '0);
    send_cmd(cal_pkg::KIND_START, '0, '0);
    send_cmd(KIND_SPARE_LO, $urandom, 8'd255);
    send_cmd(KIND_SPARE_HI, $urandom, 8'd170);
    send_cmd(cal_pkg::KIND_INSERT, 32'h0000_0001, '0);
    send_cmd(cal_pkg::KIND_CLEAR, '0, '0);
    send_cmd(cal_pkg::KIND_REMOVE, '0, '0);

    // fill to capacity with inserts and appends at moving cursor positions
    steady = ($urandom_range(0, 1) == 1);
    while (list_size < cal_pkg::CAPACITY) begin
      r = $urandom_range(0, 9);
      if (r < 4)
        send_cmd(cal_pkg::KIND_INSERT, pick_value(), '0);
      else if (r < 7)
        send_cmd(cal_pkg::KIND_APPEND, pick_value(), '0);
      else if (r < 8)
        send_cmd(cal_pkg::KIND_GOTO, '0,
                 cal_pkg::POS_W'($urandom_range(0, (list_size > 0) ? list_size - 1 : 0)));
      else if (r < 9)
        send_cmd(cal_pkg::KIND_NEXT, '0, '0);
      else
        send_cmd(cal_pkg::KIND_PREV, '0, '0);
    end

    // full list: rejected growth, deep shifts and scans
    steady = 1'b0;
    send_cmd(cal_pkg::KIND_APPEND, $urandom, '0);
    send_cmd(cal_pkg::KIND_INSERT, $urandom, '0);
    send_cmd(cal_pkg::KIND_GOTO, '0, 8'd255);
    send_cmd(cal_pkg::KIND_READ, '0, '0);
    send_cmd(cal_pkg::KIND_END, '0, '0);
    send_cmd(cal_pkg::KIND_REMOVE, '0, '0);
    send_cmd(cal_pkg::KIND_APPEND, TAIL_MARK, '0);
    send_cmd(cal_pkg::KIND_SEARCH, TAIL_MARK, '0);
    send_cmd(cal_pkg::KIND_SEARCH, 32'h7654_3210, '0);
    send_cmd(cal_pkg::KIND_GOTO, '0, 8'd0);
    send_cmd(cal_pkg::KIND_REMOVE, '0, '0);
    send_cmd(cal_pkg::KIND_INSERT, 32'hFFFF_FFFF, '0);
    send_cmd(cal_pkg::KIND_NEXT, '0, '0);
    send_cmd(cal_pkg::KIND_CLEAR, '0, '0);

    // random mix, lists kept short by occasional clears
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0)
        steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 20)
        send_cmd(cal_pkg::KIND_INSERT, pick_value(), cal_pkg::POS_W'($urandom));
      else if (r < 35)
        send_cmd(cal_pkg::KIND_APPEND, pick_value(), cal_pkg::POS_W'($urandom));
      else if (r < 48)
        send_cmd(cal_pkg::KIND_REMOVE, $urandom, cal_pkg::POS_W'($urandom));
      else if (r < 52)
        send_cmd(cal_pkg::KIND_START, $urandom, cal_pkg::POS_W'($urandom));
      else if (r < 56)
        send_cmd(cal_pkg::KIND_END, $urandom, cal_pkg::POS_W'($urandom));
      else if (r < 62)
        send_cmd(cal_pkg::KIND_PREV, $urandom, cal_pkg::POS_W'($urandom));
      else if (r < 68)
        send_cmd(cal_pkg::KIND_NEXT, $urandom, cal_pkg::POS_W'($urandom));
      else if (r < 77)
        send_cmd(cal_pkg::KIND_GOTO, $urandom, pick_position());
      else if (r < 83)
        send_cmd(cal_pkg::KIND_READ, $urandom, cal_pkg::POS_W'($urandom));
      else if (r < 94)
        send_cmd(cal_pkg::KIND_SEARCH, pick_value(), cal_pkg::POS_W'($urandom));
      else if (r < 96)
        send_cmd(cal_pkg::KIND_CLEAR, $urandom, cal_pkg::POS_W'($urandom));
      else
        send_cmd(cal_pkg::KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), $urandom,
                 cal_pkg::POS_W'($urandom));
    end
    cmd.valid <= 1'b0;

    // drain, then allow for a stray late result
    steady = 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d requests sent, %0d results checked", sent, replies_checked);
    $display("summary: list reached %0d of %0d entries, incl. full, empty, range cases",
             peak_size, cal_pkg::CAPACITY);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
